// File: rtl/cmsf_pkg.sv
// package for the column mode stroke filter: field widths, register map,
// reset values and the luma binning function. no dependencies
`default_nettype none

package cmsf_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int BIN_COUNT        = 256;
  localparam int MAX_HEIGHT       = 4096;
  localparam int STROKE_CAP       = 32;
  localparam int PIX_W            = 8;
  localparam int ROW_W            = 12;
  localparam int PASS_MIN_COUNT   = 15;

  localparam logic [PIX_W-1:0] NEUTRAL_CHROMA = 8'd128;

  // register indexes on the apb port (byte address = 4 * index)
  localparam logic [1:0] REG_STROKE = 2'd0;
  localparam logic [1:0] REG_SMOOTH = 2'd1;
  localparam logic [1:0] REG_CMODE  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [5:0]       STROKE_RST = 6'd4;
  localparam logic [7:0]       SMOOTH_RST = 8'd5;
  localparam logic             CMODE_RST  = 1'b1;
  localparam logic [ROW_W-1:0] HEIGHT_RST = 12'd480;

  // floor(luma * top / 255) without a divider
  function automatic logic [7:0] bin_of(input logic [7:0] luma, input logic [7:0] top);
    logic [15:0] x;
    logic [8:0]  r;
    x = luma * top;
    r = {1'b0, x[7:0]} + {1'b0, x[15:8]};
    bin_of = x[15:8] + ((r >= 9'd255) ? 8'd1 : 8'd0);
  endfunction

endpackage

`default_nettype wire

// File: rtl/cmsf_div.sv
// three-lane restoring divider sharing one divisor, one quotient bit per cycle
// depends on nothing outside this file
`default_nettype none

module cmsf_div #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num [3],
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo [3]
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DEN_W-1:0] rem_r;
    logic [NUM_W-1:0] q_r;
    logic [DEN_W:0]   sh;
    assign sh = {rem_r, q_r[NUM_W-1]};
    always_ff @(posedge clk) begin
      if (start) begin
        rem_r <= '0;
        q_r   <= num[l];
      end else if (busy_r) begin
        if (sh >= {1'b0, den}) begin
          rem_r <= DEN_W'(sh - {1'b0, den});
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= sh[DEN_W-1:0];
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
      end
    end
    assign quo[l] = q_r;
  end

  assign done = done_r;

endmodule

`default_nettype wire

// File: rtl/column_mode_stroke_filter_core.sv
// after its last needed pixel, a row goes through the window walk, the bin scan, the divide
// and the emit step.
// throughput: one pixel at a time; set by the serial window walk (a read and a write per
// entry on the bin memory) and the bin scan (one bin per cycle).
// reset: synchronous active-low; then a pass over all 256 bins zeroes the bin memory
// while in_tready stays low. registers take their reset values at once.
`default_nettype none

module column_mode_stroke_filter_core
  import cmsf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // pix_luma, pix_cb, pix_cr
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,   // out_luma, out_cb, out_cr, out_row, zero pad
  output logic             out_tlast,   // last_of_column
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int PW    = AW + 2;
  localparam int CAP   = (WINDOW_DEPTH / 2 > STROKE_CAP) ? STROKE_CAP : WINDOW_DEPTH / 2;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = CNT_W + PIX_W;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sy;
    logic [SUM_W-1:0] scb;
    logic [SUM_W-1:0] scr;
  } bin_t;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_SELF  = 4'd3;
  localparam logic [3:0] ST_SELFW = 4'd4;
  localparam logic [3:0] ST_RING  = 4'd5;
  localparam logic [3:0] ST_BRD   = 4'd6;
  localparam logic [3:0] ST_BWR   = 4'd7;
  localparam logic [3:0] ST_SCAN  = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic [5:0]       stroke_r;
  logic [7:0]       smooth_r;
  logic             cmode_r;
  logic [ROW_W-1:0] height_r;

  logic [ROW_W-1:0] rx_r, ny_r, j_r, hi_r;
  logic [AW-1:0]    wp_r, yp_r, jp_r;
  logic [8:0]       clr_r, si_r;
  logic             sv_r;
  logic [7:0]       sa_r, ba_r;
  logic [23:0]      self_r, pix_r;
  logic [CNT_W-1:0] best_cnt_r;
  logic [SUM_W-1:0] best_y_r, best_cb_r, best_cr_r;

  logic             out_valid_r, out_last_r;
  logic [39:0]      out_data_r;

  // memories
  logic [23:0]      ring_mem [WINDOW_DEPTH];
  logic [23:0]      ring_rd_r;
  logic [AW-1:0]    ring_ra;
  logic             ring_re;
  bin_t             bin_mem [BIN_COUNT];
  bin_t             bin_rd_r, bin_wd;
  logic [7:0]       bin_ra, bin_wa;
  logic             bin_re, bin_we;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // geometry
  logic [5:0]       s_act;
  logic [ROW_W-1:0] h_act, hm1, e12, lo12;
  logic [ROW_W:0]   ys, ny1, need;
  logic [PW-1:0]    lo_t, lo_w;
  logic [AW-1:0]    lo_ptr;
  logic             row_rdy, in_fire, wrap, cfg_we, scan_issue, out_free;

  assign s_act = (stroke_r > 6'(CAP)) ? 6'(CAP) : stroke_r;
  always_comb begin
    if (height_r == '0) h_act = ROW_W'(1);
    else if ({1'b0, height_r} > (ROW_W+1)'(MAX_HEIGHT - 1)) h_act = ROW_W'(MAX_HEIGHT - 1);
    else h_act = height_r;
  end
  assign hm1  = h_act - 1'b1;
  assign ys   = {1'b0, ny_r} + (ROW_W+1)'(s_act);
  assign e12  = (ys > {1'b0, hm1}) ? hm1 : ys[ROW_W-1:0];
  assign ny1  = {1'b0, ny_r} + 1'b1;
  assign need = ({1'b0, e12} > ny1) ? {1'b0, e12} : ny1;
  assign row_rdy = (ny_r < h_act) && (need <= {1'b0, rx_r});
  assign lo12 = (ny_r >= ROW_W'(s_act)) ? ny_r - ROW_W'(s_act) : '0;
  assign lo_t = PW'(yp_r) + PW'(WINDOW_DEPTH) - PW'(s_act);
  assign lo_w = (lo_t >= PW'(WINDOW_DEPTH)) ? lo_t - PW'(WINDOW_DEPTH) : lo_t;
  assign lo_ptr = (ny_r >= ROW_W'(s_act)) ? lo_w[AW-1:0] : '0;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign wrap      = (rx_r >= h_act) || (ny_r >= h_act);
  assign cfg_we    = cfg_psel && cfg_penable && cfg_pwrite;
  assign scan_issue = (state_r == ST_SCAN) && (si_r <= {1'b0, smooth_r});
  assign out_free  = !out_valid_r || out_tready;

  // divider
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_num [3];
  logic [SUM_W-1:0] div_quo [3];

  assign div_num[0] = best_y_r;
  assign div_num[1] = best_cb_r;
  assign div_num[2] = best_cr_r;
  assign div_start  = (state_r == ST_SCAN) && !scan_issue && !sv_r;

  cmsf_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (best_cnt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ring memory
  always_comb begin
    ring_re = 1'b0;
    ring_ra = jp_r;
    if (state_r == ST_SELF) begin
      ring_re = 1'b1;
      ring_ra = yp_r;
    end else if (state_r == ST_RING && j_r < hi_r) begin
      ring_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) ring_mem[wrap ? '0 : wp_r] <= in_tdata;
    if (ring_re) ring_rd_r <= ring_mem[ring_ra];
  end

  // bin memory: read-modify-write is serialized by the sequencer, scan clears behind itself
  bin_t cur;
  assign cur = bin_rd_r;

  always_comb begin
    bin_re = 1'b0;
    bin_ra = si_r[7:0];
    bin_we = 1'b0;
    bin_wa = sa_r;
    bin_wd = '0;
    case (state_r)
      ST_CLR: begin
        bin_we = 1'b1;
        bin_wa = clr_r[7:0];
      end
      ST_BRD: begin
        bin_re = 1'b1;
        bin_ra = bin_of(ring_rd_r[7:0], smooth_r);
      end
      ST_BWR: begin
        bin_we     = 1'b1;
        bin_wa     = ba_r;
        bin_wd.cnt = cur.cnt + 1'b1;
        bin_wd.sy  = cur.sy  + SUM_W'(pix_r[7:0]);
        bin_wd.scb = cur.scb + SUM_W'(pix_r[15:8]);
        bin_wd.scr = cur.scr + SUM_W'(pix_r[23:16]);
      end
      ST_SCAN: begin
        bin_re = scan_issue;
        bin_we = sv_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (bin_re) bin_rd_r <= bin_mem[bin_ra];
  end

  // result selection
  logic             has_win, lum_ok;
  logic [7:0]       r_y, r_cb, r_cr;
  assign has_win = (best_cnt_r != '0);
  assign lum_ok  = ({1'b0, best_cnt_r} > (CNT_W+1)'(PASS_MIN_COUNT));
  always_comb begin
    if (cmode_r) begin
      r_y  = has_win ? div_quo[0][7:0] : self_r[7:0];
      r_cb = has_win ? div_quo[1][7:0] : self_r[15:8];
      r_cr = has_win ? div_quo[2][7:0] : self_r[23:16];
    end else begin
      r_y  = lum_ok ? div_quo[0][7:0] : self_r[7:0];
      r_cb = NEUTRAL_CHROMA;
      r_cr = NEUTRAL_CHROMA;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (clr_r == 9'(BIN_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = row_rdy ? ST_SELF : ST_IDLE;
      ST_SELF:  state_nxt = ST_SELFW;
      ST_SELFW: state_nxt = ST_RING;
      ST_RING:  state_nxt = (j_r < hi_r) ? ST_BRD : ST_SCAN;
      ST_BRD:   state_nxt = ST_BWR;
      ST_BWR:   state_nxt = ST_RING;
      ST_SCAN:  if (div_start) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_CHECK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      stroke_r    <= STROKE_RST;
      smooth_r    <= SMOOTH_RST;
      cmode_r     <= CMODE_RST;
      height_r    <= HEIGHT_RST;
      rx_r        <= '0;
      ny_r        <= '0;
      wp_r        <= '0;
      yp_r        <= '0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + 1'b1;

      if (cfg_we) begin
        case (cfg_paddr[3:2])
          REG_STROKE: stroke_r <= cfg_pwdata[5:0];
          REG_SMOOTH: smooth_r <= cfg_pwdata[7:0];
          REG_CMODE:  cmode_r  <= cfg_pwdata[0];
          REG_HEIGHT: height_r <= cfg_pwdata[ROW_W-1:0];
          default: ;
        endcase
        if (cfg_paddr[3:2] == REG_STROKE || cfg_paddr[3:2] == REG_HEIGHT) begin
          rx_r <= '0;
          ny_r <= '0;
          wp_r <= '0;
          yp_r <= '0;
        end
      end

      if (in_fire) begin
        rx_r <= (wrap ? '0 : rx_r) + 1'b1;
        wp_r <= ptr_inc(wrap ? '0 : wp_r);
        if (wrap) begin
          ny_r <= '0;
          yp_r <= '0;
        end
      end

      // column finished: start over
      if (state_r == ST_CHECK && !row_rdy && ny_r >= h_act) begin
        rx_r <= '0;
        ny_r <= '0;
        wp_r <= '0;
        yp_r <= '0;
      end

      if (state_r == ST_CHECK) begin
        j_r        <= lo12;
        jp_r       <= lo_ptr;
        hi_r       <= e12;
        best_cnt_r <= '0;
        best_y_r   <= '0;
        best_cb_r  <= '0;
        best_cr_r  <= '0;
      end
      if (state_r == ST_SELFW) self_r <= ring_rd_r;
      if (state_r == ST_RING && j_r < hi_r) begin
        j_r  <= j_r + 1'b1;
        jp_r <= ptr_inc(jp_r);
      end
      if (state_r == ST_RING) begin
        si_r <= '0;
        sv_r <= 1'b0;
      end
      if (state_r == ST_BRD) begin
        pix_r <= ring_rd_r;
        ba_r  <= bin_ra;
      end

      if (state_r == ST_SCAN) begin
        sv_r <= scan_issue;
        sa_r <= si_r[7:0];
        if (scan_issue) si_r <= si_r + 1'b1;
        // strict compare keeps the lowest bin on ties
        if (sv_r && cur.cnt > best_cnt_r) begin
          best_cnt_r <= cur.cnt;
          best_y_r   <= cur.sy;
          best_cb_r  <= cur.scb;
          best_cr_r  <= cur.scr;
        end
      end

      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        ny_r        <= ny_r + 1'b1;
        yp_r        <= ptr_inc(yp_r);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= {4'b0, ny_r, r_cr, r_cb, r_y};
      out_last_r <= (ny_r == hm1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_STROKE: cfg_prdata = {26'b0, stroke_r};
      REG_SMOOTH: cfg_prdata = {24'b0, smooth_r};
      REG_CMODE:  cfg_prdata = {31'b0, cmode_r};
      REG_HEIGHT: cfg_prdata = {20'b0, height_r};
      default:    cfg_prdata = '0;
    endcase
  end
  assign cfg_pready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/cmsf_chk.sv
// port-level checks for column_mode_stroke_filter_core, attached by bind
// depends on the top level's port names only
`default_nettype none

module cmsf_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // bin memory clearing pass keeps input closed right after reset
  a_clr_closed: assert property (@(posedge clk) $rose(rst_n) |-> !in_tready)
    else $error("input open during clearing pass");

  // one pixel at a time: busy right after a transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open right after transaction");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind column_mode_stroke_filter_core cmsf_chk u_cmsf_chk (.*);

`default_nettype wire
